>>> hdl/ioct_pkg.sv
package ioct_pkg;

  // Slot count of the buffer; a power of two so a slot is the low bits of an offset.
  localparam int DEPTH   = 16;
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SEQ_W   = 16;
  localparam int CODE_W  = 8;
  localparam int CAP_W   = 5;
  localparam int PEND_W  = 5;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;

  localparam logic [OP_W-1:0] OP_SUBMIT   = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OP_W-1:0] OP_RETIRE   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_READY = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd4;
  localparam logic [STAT_W-1:0] ST_REFUSED   = 3'd5;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SEQ_W-1:0]  seq_t;

  typedef struct packed {
    logic  en;
    slot_t idx;
    logic  done;
    logic  code_en;
    code_t code;
  } slot_wr_t;

  typedef struct packed {
    logic  head_done;
    logic  next_done;
    code_t head_code;
  } slot_rd_t;

endpackage

>>> hdl/ioct_ifs.sv
interface ioct_in_if;
  logic                          valid;
  logic                          ready;
  logic [ioct_pkg::OP_W-1:0]     op;
  logic [ioct_pkg::SEQ_W-1:0]    seq_in;
  logic [ioct_pkg::CODE_W-1:0]   result_code;

  modport source (output valid, output op, output seq_in, output result_code, input ready);
  modport sink   (input valid, input op, input seq_in, input result_code, output ready);
endinterface

interface ioct_out_if;
  logic                          valid;
  logic                          ready;
  logic [ioct_pkg::STAT_W-1:0]   status;
  logic [ioct_pkg::SEQ_W-1:0]    seq_out;
  logic [ioct_pkg::CODE_W-1:0]   job_result;
  logic                          job_failed;
  logic [ioct_pkg::PEND_W-1:0]   pending;
  logic                          head_ready;

  modport source (output valid, output status, output seq_out, output job_result,
                  output job_failed, output pending, output head_ready, input ready);
  modport sink   (input valid, input status, input seq_out, input job_result,
                  input job_failed, input pending, input head_ready, output ready);
endinterface

>>> hdl/ioct_slots.sv
module ioct_slots (
  input  logic               clk,
  input  logic               rst_n,
  input  ioct_pkg::slot_wr_t wr,
  input  ioct_pkg::slot_t    head_idx,
  output ioct_pkg::slot_rd_t rd
);
  import ioct_pkg::*;

  logic [DEPTH-1:0] done_r;
  code_t            code_r [DEPTH];
  slot_t            next_idx;

  // Done flags reset to zero; result codes are only read after a complete wrote them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else if (wr.en) begin
      done_r[wr.idx] <= wr.done;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.code_en) begin
      code_r[wr.idx] <= wr.code;
    end
  end

  assign next_idx     = head_idx + slot_t'(1);
  assign rd.head_done = done_r[head_idx];
  assign rd.next_done = done_r[next_idx];
  assign rd.head_code = code_r[head_idx];

endmodule

>>> hdl/in_order_completion_tracker.sv
// Channel | Direction | Fields
// in_ch   | sink      | op, seq_in, result_code
// out_ch  | source    | status, seq_out, job_result, job_failed, pending, head_ready
// cfg     | write     | capacity (cfg_we, cfg_wdata)
//
// Each word is held in an input register, evaluated by one short
// pass over the slot table and counters, and lands in the result register.
// One word per cycle is sustained while out_ch is not stalled.
// A stall on out_ch holds the result register, and the input register then
// holds its word, so in_ch.ready drops only when both are occupied and out_ch
// is stalled.
// Reset (rst_n, synchronous) clears all counters, done flags and capacity.
module in_order_completion_tracker (
  input  logic                      clk,
  input  logic                      rst_n,
  ioct_in_if.sink                   in_ch,
  ioct_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [ioct_pkg::CAP_W-1:0] cfg_wdata
);
  import ioct_pkg::*;

  // Configuration: the in-flight limit.
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] limit;

  // Input register.
  logic             in_vld_r;
  logic [OP_W-1:0]  op_r;
  seq_t             seq_r;
  code_t            code_in_r;

  // Tracker state.
  seq_t             sub_cnt_r, sub_cnt_nxt;
  seq_t             ret_cnt_r, ret_cnt_nxt;
  logic [CNT_W-1:0] flight_r, flight_nxt;
  slot_t            head_r, head_nxt;

  // Result register.
  logic             out_vld_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  seq_t             seq_out_r, seq_out_nxt;
  code_t            job_res_r, job_res_nxt;
  logic             failed_r, failed_nxt;
  logic             head_rdy_r, head_rdy_nxt;
  logic [PEND_W-1:0] pend_r;

  logic             fire;
  seq_t             offset;
  slot_wr_t         wr;
  slot_rd_t         rd;

  ioct_slots u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .head_idx (head_r),
    .rd       (rd)
  );

  // A zero capacity, or one above the depth, means the whole buffer.
  always_comb begin
    if (cap_r == '0 || CNT_W'(cap_r) > CNT_W'(DEPTH)) begin
      limit = CNT_W'(DEPTH);
    end else begin
      limit = CNT_W'(cap_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // The evaluation stage advances when the result register is free or being taken.
  assign fire        = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r      <= in_ch.op;
      seq_r     <= in_ch.seq_in;
      code_in_r <= in_ch.result_code;
    end
  end

  // Distance of a completing number from the oldest job in flight.
  assign offset = seq_r - ret_cnt_r;

  always_comb begin
    sub_cnt_nxt  = sub_cnt_r;
    ret_cnt_nxt  = ret_cnt_r;
    flight_nxt   = flight_r;
    head_nxt     = head_r;
    status_nxt   = ST_OK;
    seq_out_nxt  = '0;
    job_res_nxt  = '0;
    failed_nxt   = 1'b0;
    head_rdy_nxt = (flight_r != '0) && rd.head_done;
    wr           = '0;
    wr.code      = code_in_r;

    unique case (op_r)
      OP_SUBMIT: begin
        if (flight_r >= limit) begin
          status_nxt = ST_FULL;
        end else begin
          // The new slot sits right after the youngest job; its flag starts clear.
          wr.en       = 1'b1;
          wr.idx      = head_r + slot_t'(flight_r);
          wr.done     = 1'b0;
          seq_out_nxt = sub_cnt_r;
          sub_cnt_nxt = sub_cnt_r + seq_t'(1);
          flight_nxt  = flight_r + CNT_W'(1);
        end
      end
      OP_COMPLETE: begin
        if (offset >= SEQ_W'(flight_r)) begin
          status_nxt = ST_UNKNOWN;
        end else begin
          // A repeated complete simply overwrites the stored code.
          wr.en        = 1'b1;
          wr.idx       = head_r + slot_t'(offset);
          wr.done      = 1'b1;
          wr.code_en   = 1'b1;
          head_rdy_nxt = rd.head_done || (slot_t'(offset) == '0);
        end
      end
      OP_RETIRE: begin
        if (flight_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (!rd.head_done) begin
          status_nxt = ST_NOT_READY;
        end else begin
          wr.en        = 1'b1;
          wr.idx       = head_r;
          wr.done      = 1'b0;
          seq_out_nxt  = ret_cnt_r;
          job_res_nxt  = rd.head_code;
          failed_nxt   = rd.head_code != '0;
          head_nxt     = head_r + slot_t'(1);
          ret_cnt_nxt  = ret_cnt_r + seq_t'(1);
          flight_nxt   = flight_r - CNT_W'(1);
          // The head moves on, so readiness comes from the following slot.
          head_rdy_nxt = (flight_r != CNT_W'(1)) && rd.next_done;
        end
      end
      OP_CLEAR: begin
        if (flight_r != '0) begin
          status_nxt = ST_REFUSED;
        end else begin
          sub_cnt_nxt = '0;
          ret_cnt_nxt = '0;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase

    // Slot writes only take effect when the word actually advances.
    wr.en = wr.en && fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_cnt_r <= '0;
      ret_cnt_r <= '0;
      flight_r  <= '0;
      head_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        sub_cnt_r <= sub_cnt_nxt;
        ret_cnt_r <= ret_cnt_nxt;
        flight_r  <= flight_nxt;
        head_r    <= head_nxt;
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r   <= status_nxt;
      seq_out_r  <= seq_out_nxt;
      job_res_r  <= job_res_nxt;
      failed_r   <= failed_nxt;
      head_rdy_r <= head_rdy_nxt;
      pend_r     <= PEND_W'(flight_nxt);
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = status_r;
  assign out_ch.seq_out    = seq_out_r;
  assign out_ch.job_result = job_res_r;
  assign out_ch.job_failed = failed_r;
  assign out_ch.pending    = pend_r;
  assign out_ch.head_ready = head_rdy_r;

endmodule

>>> bench/in_order_completion_tracker_test.sv
module in_order_completion_tracker_test;
  import ioct_pkg::*;

  // Cycles in which no word moves on either channel before the run is declared hung.
  // A correct run never sees more than a couple of idle bursts in a row.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Words per random phase; eight phases give about 850 words with the directed part.
  localparam int unsigned PHASE_WORDS = 104;
  localparam int unsigned PHASES      = 8;

  // One result word as the block reports it.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    seq_t              seq_out;
    code_t             job_result;
    logic              job_failed;
    logic [PEND_W-1:0] pending;
    logic              head_ready;
  } tracker_result_t;

  // The scoreboard carries its own copy of the buffer: which slots are done, the
  // code stored in each slot, both sequence counters, the jobs in flight and the
  // slot of the oldest job. Every accepted input word advances this copy and
  // queues the result word the block must produce for it.
  class completion_scoreboard;
    bit                done_q[DEPTH];
    code_t             code_mem[DEPTH];
    seq_t              next_seq;
    seq_t              oldest_seq;
    int unsigned       jobs_out;
    int unsigned       oldest_slot;
    logic [CAP_W-1:0]  cap_reg;
    tracker_result_t   expected_q[$];
    int unsigned       errors;
    int unsigned       words_checked;
    int unsigned       jobs_retired;
    int unsigned       status_seen[8];

    function new();
      for (int i = 0; i < DEPTH; i++) done_q[i] = 1'b0;
      next_seq    = '0;
      oldest_seq  = '0;
      jobs_out    = 0;
      oldest_slot = 0;
      cap_reg     = '0;
      errors      = 0;
      words_checked = 0;
      jobs_retired  = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
    endfunction

    // A capacity of zero, or one beyond the slot count, means the whole buffer.
    function int unsigned cap_limit();
      if (cap_reg == 0 || cap_reg > DEPTH) return DEPTH;
      return cap_reg;
    endfunction

    function void note_word(logic [OP_W-1:0] op, seq_t seq, code_t code);
      tracker_result_t r;
      int unsigned     slot;
      seq_t            offset;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_SUBMIT: begin
          if (jobs_out >= cap_limit()) begin
            r.status = ST_FULL;
          end else begin
            slot = (oldest_slot + jobs_out) % DEPTH;
            done_q[slot] = 1'b0;
            r.seq_out = next_seq;
            next_seq++;
            jobs_out++;
          end
        end
        OP_COMPLETE: begin
          // The distance from the oldest number decides whether the job is in flight;
          // numbers below the oldest wrap around to large distances.
          offset = seq - oldest_seq;
          if (offset >= jobs_out) begin
            r.status = ST_UNKNOWN;
          end else begin
            slot = (oldest_slot + offset) % DEPTH;
            done_q[slot] = 1'b1;
            code_mem[slot] = code;
          end
        end
        OP_RETIRE: begin
          if (jobs_out == 0) begin
            r.status = ST_EMPTY;
          end else if (!done_q[oldest_slot]) begin
            r.status = ST_NOT_READY;
          end else begin
            r.seq_out    = oldest_seq;
            r.job_result = code_mem[oldest_slot];
            r.job_failed = (code_mem[oldest_slot] != 0);
            done_q[oldest_slot] = 1'b0;
            oldest_slot = (oldest_slot + 1) % DEPTH;
            oldest_seq++;
            jobs_out--;
            jobs_retired++;
          end
        end
        OP_CLEAR: begin
          if (jobs_out > 0) begin
            r.status = ST_REFUSED;
          end else begin
            next_seq   = '0;
            oldest_seq = '0;
          end
        end
      endcase
      r.pending    = PEND_W'(jobs_out);
      r.head_ready = (jobs_out > 0) && done_q[oldest_slot];
      status_seen[r.status]++;
      expected_q.push_back(r);
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_word(tracker_result_t got);
      tracker_result_t want;
      bit              ok;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %0h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      words_checked++;
      ok = field_ok("status", want.status, got.status);
      ok &= field_ok("seq_out", want.seq_out, got.seq_out);
      ok &= field_ok("job_result", want.job_result, got.job_result);
      ok &= field_ok("job_failed", want.job_failed, got.job_failed);
      ok &= field_ok("pending", want.pending, got.pending);
      ok &= field_ok("head_ready", want.head_ready, got.head_ready);
      if (!ok) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  ioct_in_if  in_ch();
  ioct_out_if out_ch();

  in_order_completion_tracker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  completion_scoreboard sb;
  int unsigned quiet_cycles = 0;
  // Idle bursts on the input and stalls on the output are switched off for the last phase.
  bit src_idle_on  = 1'b1;
  bit sink_stall_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side is ready most of the time, with random stall bursts.
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (sink_stall_on && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 17);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result words are checked at the edge where they are accepted. The same block
  // counts edges at which no word moved, for the watchdog.
  always @(posedge clk) begin : result_monitor
    tracker_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status     = out_ch.status;
      got.seq_out    = out_ch.seq_out;
      got.job_result = out_ch.job_result;
      got.job_failed = out_ch.job_failed;
      got.pending    = out_ch.pending;
      got.head_ready = out_ch.head_ready;
      sb.check_word(got);
    end
    if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      quiet_cycles <= 0;
    else if (rst_n)
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Sends one word and returns at the edge where it is accepted. The valid line is
  // left high so that a following word goes out without a gap; it is lowered only
  // for an idle burst or when the input side goes quiet.
  task automatic send_word(input logic [OP_W-1:0] op, input seq_t seq, input code_t code);
    int unsigned gap;
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.seq_in      <= seq;
    in_ch.result_code <= code;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(op, seq, code);
  endtask

  // Stops sending and waits until every expected result word has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The capacity register is written only while the block is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.cap_reg = value;
  endtask

  // Picks one random word. Most words follow the state of the buffer so that jobs
  // really complete out of order and retire in order; the rest are noise: numbers
  // that are not in flight, retires of unfinished jobs, counter resets.
  task automatic send_random_word();
    logic [OP_W-1:0] op;
    seq_t            seq;
    code_t           code;
    int unsigned     pick;
    int unsigned     submit_pct;
    pick = $urandom_range(0, 99);
    submit_pct = (sb.jobs_out >= sb.cap_limit()) ? 8 : 30;
    if (pick < submit_pct)
      op = OP_SUBMIT;
    else if (pick < 65)
      op = OP_COMPLETE;
    else if (pick < ((sb.jobs_out == 0) ? 85 : 96))
      op = OP_RETIRE;
    else
      op = OP_CLEAR;
    seq  = seq_t'($urandom_range(0, 16'hFFFF));
    code = ($urandom_range(0, 1) == 0) ? code_t'(0) : code_t'($urandom_range(0, 255));
    if (op == OP_COMPLETE) begin
      pick = $urandom_range(0, 9);
      if (sb.jobs_out > 0 && pick < 3)
        seq = sb.oldest_seq;
      else if (sb.jobs_out > 0 && pick < 8)
        seq = sb.oldest_seq + seq_t'($urandom_range(0, sb.jobs_out - 1));
      else if (pick == 8)
        seq = sb.oldest_seq + seq_t'(sb.jobs_out);
    end
    send_word(op, seq, code);
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [PHASES];
    sb = new();
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_SUBMIT;
    in_ch.seq_in      <= '0;
    in_ch.result_code <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, capacity still at its reset value of zero (whole buffer).
    send_word(OP_RETIRE, 16'h0000, 8'h00);     // retire with nothing in flight
    send_word(OP_COMPLETE, 16'h0000, 8'h00);   // complete of a number never submitted
    send_word(OP_CLEAR, 16'h0000, 8'h00);      // counter reset while empty is honored
    send_word(OP_SUBMIT, 16'hFFFF, 8'hFF);
    send_word(OP_SUBMIT, 16'h0000, 8'h00);
    send_word(OP_SUBMIT, 16'hFFFF, 8'h00);
    send_word(OP_RETIRE, 16'h0000, 8'h00);     // oldest job not done yet
    send_word(OP_COMPLETE, 16'h0001, 8'hFF);   // younger job finishes first
    send_word(OP_COMPLETE, 16'h0000, 8'h00);
    send_word(OP_COMPLETE, 16'h0000, 8'h80);   // completing twice overwrites the code
    send_word(OP_CLEAR, 16'h0000, 8'h00);      // refused while jobs are in flight
    send_word(OP_COMPLETE, 16'hFFFF, 8'h01);   // number below the oldest, not in flight
    send_word(OP_RETIRE, 16'h0000, 8'h00);
    send_word(OP_RETIRE, 16'h0000, 8'h00);
    send_word(OP_COMPLETE, 16'h0002, 8'h00);
    send_word(OP_RETIRE, 16'h0000, 8'h00);
    send_word(OP_RETIRE, 16'h0000, 8'h00);
    // A capacity of one makes the second submit report full.
    write_capacity(5'd1);
    send_word(OP_SUBMIT, 16'h0000, 8'h00);
    send_word(OP_SUBMIT, 16'h0000, 8'h00);
    send_word(OP_COMPLETE, 16'h0003, 8'h5A);
    send_word(OP_RETIRE, 16'h0000, 8'h00);

    // Random phases, each under its own capacity: whole buffer, the smallest
    // limits, values beyond the slot count, zero again, one picked at random and four.
    phase_caps = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd17, 5'd0,
                   CAP_W'($urandom_range(3, 15)), 5'd4};
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      if (p == PHASES - 1) begin
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
      end
      for (int n = 0; n < PHASE_WORDS; n++) send_random_word();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d result words over %0d capacity settings; %0d jobs retired in order.",
             sb.words_checked, PHASES + 2, sb.jobs_retired);
    $display("Rejections seen: %0d full, %0d empty, %0d not ready, %0d unknown, %0d refused.",
             sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOT_READY],
             sb.status_seen[ST_UNKNOWN], sb.status_seen[ST_REFUSED]);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
